/* src/pfm_pkg.sv */
// Package for the prime field m-sequence generator.
// Holds field codes, register indexes, reset values and the GF(p) digit helpers.
// No dependencies.
`timescale 1ns / 1ps

package pfm_pkg;

  localparam int MAX_DEGREE_DEF = 30;
  localparam int WEIGHT_STAGES  = 30;
  localparam int DIGIT_W        = 3;
  localparam int WEIGHTS_W      = 45;
  localparam int POS_W          = 30;
  localparam int DEGREE_W       = 5;
  localparam int BASE_W         = 2;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 45;

  typedef logic [DIGIT_W-1:0] digit_t;

  typedef enum logic [1:0] {
    BASE_BIN = 2'd0,
    BASE_TER = 2'd1,
    BASE_QUI = 2'd2
  } base_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BASE    = 3'd0,
    REG_DEGREE  = 3'd1,
    REG_W_LOW   = 3'd2,
    REG_W_HIGH  = 3'd3,
    REG_PERIOD  = 3'd4
  } reg_idx_e;

  localparam logic [DEGREE_W-1:0]  DEGREE_RST = 5'd10;
  localparam logic [WEIGHTS_W-1:0] W_LOW_RST  = 45'd134217792;
  localparam logic [WEIGHTS_W-1:0] W_HIGH_RST = 45'd0;
  localparam logic [POS_W-1:0]     PERIOD_RST = 30'd1023;

  typedef struct packed {
    base_e                        base;
    logic [DEGREE_W-1:0]          degree;
    logic [2*WEIGHTS_W-1:0]       weights;
    logic [POS_W-1:0]             period;
  } pfm_cfg_t;

  function automatic base_e decode_base(logic [BASE_W-1:0] code);
    base_e b;
    unique case (code)
      2'd1:    b = BASE_TER;
      2'd2:    b = BASE_QUI;
      default: b = BASE_BIN;
    endcase
    return b;
  endfunction

  function automatic digit_t base_value(base_e b);
    digit_t p;
    unique case (b)
      BASE_TER: p = 3'd3;
      BASE_QUI: p = 3'd5;
      default:  p = 3'd2;
    endcase
    return p;
  endfunction

  // reduce a 0..7 digit into 0..p-1
  function automatic digit_t red_digit(digit_t v, base_e b);
    digit_t r;
    unique case (b)
      BASE_TER: r = (v >= 3'd6) ? v - 3'd6 : ((v >= 3'd3) ? v - 3'd3 : v);
      BASE_QUI: r = (v >= 3'd5) ? v - 3'd5 : v;
      default:  r = {2'b00, v[0]};
    endcase
    return r;
  endfunction

  // product of two reduced digits, mod p
  function automatic digit_t mul_mod(digit_t a, digit_t c, base_e b);
    logic [4:0] prod;
    logic [4:0] r;
    prod = {2'b00, a} * {2'b00, c};
    unique case (b)
      BASE_TER: r = (prod >= 5'd3) ? prod - 5'd3 : prod;
      BASE_QUI: begin
        if (prod >= 5'd15)      r = prod - 5'd15;
        else if (prod >= 5'd10) r = prod - 5'd10;
        else if (prod >= 5'd5)  r = prod - 5'd5;
        else                    r = prod;
      end
      default:  r = {4'b0000, prod[0]};
    endcase
    return r[DIGIT_W-1:0];
  endfunction

  // sum of two reduced digits, mod p
  function automatic digit_t add_mod(digit_t a, digit_t c, base_e b);
    logic [3:0] s;
    logic [3:0] p;
    s = {1'b0, a} + {1'b0, c};
    p = {1'b0, base_value(b)};
    if (s >= p) s = s - p;
    return s[DIGIT_W-1:0];
  endfunction

  function automatic logic signed [DIGIT_W-1:0] map_symbol(digit_t d, base_e b);
    logic signed [DIGIT_W-1:0] s;
    s = d;
    unique case (b)
      BASE_TER: if (d == 3'd2) s = -3'sd1;
      BASE_QUI: begin
        if (d == 3'd3)      s = -3'sd2;
        else if (d == 3'd4) s = -3'sd1;
      end
      default:  s = (d != 3'd0) ? 3'sd1 : -3'sd1;
    endcase
    return s;
  endfunction

endpackage

/* src/prime_field_m_sequence_generator.sv */
// Top level of the prime field m-sequence generator (GF(2), GF(3), GF(5)).
// Depends on pfm_pkg, pfm_cfg_regs and pfm_feedback.
//
// One symbol per clock while the output is not stalled: every accepted request produces
// exactly one result, which passes the input register and then the output register and
// is taken when the output is not stalled. The rate is set by
// the feedback loop, which forms the new digit from the digit register through
// a mod-p multiply and a ceil(log2(MAX_DEGREE))-level mod-p adder tree and updates
// the register in the same cycle. An input register and an output register
// separate the two sides, so one more request is taken while a result waits.
// Write configuration only while no request is in flight.
`timescale 1ns / 1ps

module prime_field_m_sequence_generator #(
  parameter int MAX_DEGREE = pfm_pkg::MAX_DEGREE_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [pfm_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [pfm_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              restart_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [2:0]                 symbol_o,
  output logic [2:0]                        raw_digit_o,
  output logic                              period_end_o
);

  pfm_pkg::pfm_cfg_t cfg;

  pfm_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_wdata_i(cfg_wdata_i),
    .cfg_o      (cfg)
  );

  // input stage
  logic a_valid_q, a_valid_d;
  logic a_restart_q;
  logic accept, step;

  // generator state
  pfm_pkg::digit_t                 digit_q [MAX_DEGREE];
  pfm_pkg::digit_t                 digit_eff [MAX_DEGREE];
  logic [pfm_pkg::POS_W-1:0]       pos_q, pos_d, pos_eff;
  logic [pfm_pkg::POS_W:0]         pos_inc;
  logic                            end_d;
  pfm_pkg::digit_t                 fb_digit;

  // result stage
  logic                            out_valid_q, out_valid_d;
  logic signed [2:0]               symbol_q;
  pfm_pkg::digit_t                 raw_q;
  logic                            end_q;

  assign step       = a_valid_q & (~out_valid_q | ~out_stall_i);
  assign in_stall_o = a_valid_q & ~step;
  assign accept     = in_valid_i & ~in_stall_o;

  always_comb begin
    a_valid_d = a_valid_q;
    if (accept)    a_valid_d = 1'b1;
    else if (step) a_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else begin
      a_valid_q <= a_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_restart_q <= restart_i;
    end
  end

  always_comb begin
    for (int k = 0; k < MAX_DEGREE; k++) begin
      digit_eff[k] = a_restart_q ? pfm_pkg::digit_t'(1) : digit_q[k];
    end
    pos_eff = a_restart_q ? '0 : pos_q;
  end

  pfm_feedback #(
    .MAX_DEGREE(MAX_DEGREE)
  ) u_fb (
    .digits_i(digit_eff),
    .cfg_i   (cfg),
    .digit_o (fb_digit)
  );

  always_comb begin
    pos_inc = {1'b0, pos_eff} + 1'b1;
    end_d   = (pos_inc >= {1'b0, cfg.period});
    pos_d   = end_d ? '0 : pos_inc[pfm_pkg::POS_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < MAX_DEGREE; k++) begin
        digit_q[k] <= pfm_pkg::digit_t'(1);
      end
      pos_q <= '0;
    end else if (step) begin
      digit_q[0] <= fb_digit;
      for (int k = 1; k < MAX_DEGREE; k++) begin
        digit_q[k] <= digit_eff[k-1];
      end
      pos_q <= pos_d;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (step)              out_valid_d = 1'b1;
    else if (!out_stall_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      symbol_q <= pfm_pkg::map_symbol(fb_digit, cfg.base);
      raw_q    <= fb_digit;
      end_q    <= end_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign symbol_o     = symbol_q;
  assign raw_digit_o  = raw_q;
  assign period_end_o = end_q;

endmodule

/* src/pfm_cfg_regs.sv */
// Configuration register file for the prime field m-sequence generator.
// Depends on pfm_pkg for register indexes, reset values and the config struct.
`timescale 1ns / 1ps

module pfm_cfg_regs (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [pfm_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [pfm_pkg::CFG_DATA_W-1:0]      cfg_wdata_i,
  output pfm_pkg::pfm_cfg_t                   cfg_o
);

  pfm_pkg::base_e                        base_q;
  logic [pfm_pkg::DEGREE_W-1:0]          degree_q;
  logic [pfm_pkg::WEIGHTS_W-1:0]         w_low_q;
  logic [pfm_pkg::WEIGHTS_W-1:0]         w_high_q;
  logic [pfm_pkg::POS_W-1:0]             period_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q   <= pfm_pkg::BASE_BIN;
      degree_q <= pfm_pkg::DEGREE_RST;
      w_low_q  <= pfm_pkg::W_LOW_RST;
      w_high_q <= pfm_pkg::W_HIGH_RST;
      period_q <= pfm_pkg::PERIOD_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        pfm_pkg::REG_BASE:   base_q   <= pfm_pkg::decode_base(
                                           cfg_wdata_i[pfm_pkg::BASE_W-1:0]);
        pfm_pkg::REG_DEGREE: degree_q <= cfg_wdata_i[pfm_pkg::DEGREE_W-1:0];
        pfm_pkg::REG_W_LOW:  w_low_q  <= cfg_wdata_i[pfm_pkg::WEIGHTS_W-1:0];
        pfm_pkg::REG_W_HIGH: w_high_q <= cfg_wdata_i[pfm_pkg::WEIGHTS_W-1:0];
        pfm_pkg::REG_PERIOD: period_q <= cfg_wdata_i[pfm_pkg::POS_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o.base    = base_q;
  assign cfg_o.degree  = degree_q;
  assign cfg_o.weights = {w_high_q, w_low_q};
  assign cfg_o.period  = period_q;

endmodule

/* src/pfm_feedback.sv */
// Feedback digit for the prime field m-sequence generator: per-stage products
// mod p folded through a mod-p adder tree. Depends on pfm_pkg.
`timescale 1ns / 1ps

module pfm_feedback #(
  parameter int MAX_DEGREE = pfm_pkg::MAX_DEGREE_DEF
) (
  input  pfm_pkg::digit_t     digits_i [MAX_DEGREE],
  input  pfm_pkg::pfm_cfg_t   cfg_i,
  output pfm_pkg::digit_t     digit_o
);

  localparam int LEVELS = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;
  localparam int NPAD   = 1 << LEVELS;

  pfm_pkg::digit_t node [LEVELS+1][NPAD];

  always_comb begin
    for (int i = 0; i < NPAD; i++) begin
      node[0][i] = '0;
      if (i < MAX_DEGREE && i < pfm_pkg::WEIGHT_STAGES && i < int'(cfg_i.degree)) begin
        node[0][i] = pfm_pkg::mul_mod(
            pfm_pkg::red_digit(cfg_i.weights[3*i +: 3], cfg_i.base),
            pfm_pkg::red_digit(digits_i[i], cfg_i.base),
            cfg_i.base);
      end
    end
    for (int l = 1; l <= LEVELS; l++) begin
      for (int i = 0; i < NPAD; i++) begin
        if (i < (NPAD >> l)) begin
          node[l][i] = pfm_pkg::add_mod(node[l-1][2*i], node[l-1][2*i+1], cfg_i.base);
        end else begin
          node[l][i] = '0;
        end
      end
    end
  end

  assign digit_o = node[LEVELS][0];

endmodule

/* src/pfm_checker.sv */
// Port-level checker for the prime field m-sequence generator, bound to the top.
// Depends only on the top level's ports.
`timescale 1ns / 1ps

module pfm_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input logic signed [2:0] symbol_o,
  input logic [2:0]        raw_digit_o,
  input logic              period_end_o
);

  // the input side only backs up behind a waiting result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with no result waiting");

  // a field digit never exceeds four
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (raw_digit_o <= 3'd4))
    else $error("raw digit out of range");

  // symbol follows the digit mapping for some base
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      ((raw_digit_o == 3'd0 && (symbol_o == 3'sd0 || symbol_o == -3'sd1)) ||
       (raw_digit_o == 3'd1 && symbol_o == 3'sd1) ||
       (raw_digit_o == 3'd2 && (symbol_o == 3'sd2 || symbol_o == -3'sd1)) ||
       (raw_digit_o == 3'd3 && symbol_o == -3'sd2) ||
       (raw_digit_o == 3'd4 && symbol_o == -3'sd1)))
    else $error("symbol does not match raw digit");

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(symbol_o) && $stable(raw_digit_o) && $stable(period_end_o)))
    else $error("stalled result changed");

endmodule

bind prime_field_m_sequence_generator pfm_checker u_pfm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .symbol_o    (symbol_o),
  .raw_digit_o (raw_digit_o),
  .period_end_o(period_end_o)
);

/* sim/prime_field_m_sequence_generator_test.sv */
// Testbench for prime_field_m_sequence_generator: directed and random requests, with random
// idle cycles and output stalls. Each result is checked against a cycle-free sequence predictor.
// Depends on pfm_pkg and the generator RTL.
`timescale 1ns / 1ps

module prime_field_m_sequence_generator_test;

  typedef logic [pfm_pkg::BASE_W-1:0]    base_code_t;
  typedef logic [pfm_pkg::DEGREE_W-1:0]  degree_t;
  typedef logic [pfm_pkg::WEIGHTS_W-1:0] weights_t;
  typedef logic [pfm_pkg::POS_W-1:0]     period_t;

  localparam base_code_t BASE_SPARE = 2'd3;
  localparam weights_t   ALL_SEVENS = {pfm_pkg::WEIGHTS_W{1'b1}};
  localparam period_t    PERIOD_MAX = {pfm_pkg::POS_W{1'b1}};

  typedef struct packed {
    logic signed [2:0] symbol;
    logic [2:0]        raw_digit;
    logic              period_end;
  } m_symbol_t;

  logic                           clk_i       = 1'b0;
  logic                           rst_ni      = 1'b0;
  logic                           cfg_we_i    = 1'b0;
  logic [pfm_pkg::CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [pfm_pkg::CFG_DATA_W-1:0] cfg_wdata_i = '0;
  logic                           in_valid_i  = 1'b0;
  logic                           restart_i   = 1'b0;
  logic                           out_stall_i = 1'b0;
  logic                           in_stall_o;
  logic                           out_valid_o;
  logic signed [2:0]              symbol_o;
  logic [2:0]                     raw_digit_o;
  logic                           period_end_o;

  // predictor copy of configuration and sequence state
  base_code_t                 base_code;
  degree_t                    stage_count;
  weights_t                   taps_low;
  weights_t                   taps_high;
  period_t                    period_len;
  logic [pfm_pkg::DIGIT_W-1:0] stages [pfm_pkg::MAX_DEGREE_DEF];
  period_t                    symbol_pos;

  m_symbol_t expected_symbols [$];
  int        mismatch_count = 0;
  bit        tx_gaps        = 1'b0;
  bit        rx_stalls      = 1'b0;
  int        stall_left     = 0;

  prime_field_m_sequence_generator dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .restart_i    (restart_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .symbol_o     (symbol_o),
    .raw_digit_o  (raw_digit_o),
    .period_end_o (period_end_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  task automatic reset_model();
    base_code   = pfm_pkg::BASE_BIN;
    stage_count = pfm_pkg::DEGREE_RST;
    taps_low    = pfm_pkg::W_LOW_RST;
    taps_high   = pfm_pkg::W_HIGH_RST;
    period_len  = pfm_pkg::PERIOD_RST;
    foreach (stages[k]) stages[k] = 3'd1;
    symbol_pos  = '0;
  endtask

  // advance the predicted sequence by one request and queue the expected symbol
  task automatic next_symbol(input bit restart);
    int unsigned p;
    int unsigned active;
    int unsigned acc;
    int unsigned d;
    int unsigned w;
    int          sym;
    m_symbol_t   e;
    if (restart) begin
      foreach (stages[k]) stages[k] = 3'd1;
      symbol_pos = '0;
    end
    p = (base_code == pfm_pkg::BASE_TER) ? 3 : (base_code == pfm_pkg::BASE_QUI) ? 5 : 2;
    active = (int'(stage_count) > pfm_pkg::MAX_DEGREE_DEF) ? pfm_pkg::MAX_DEGREE_DEF
                                                           : int'(stage_count);
    acc = 0;
    for (int k = 0; k < active; k++) begin
      if (k < 15) w = {29'd0, taps_low[3*k +: 3]};
      else        w = {29'd0, taps_high[3*(k-15) +: 3]};
      acc += w * stages[k];
    end
    d = acc % p;
    for (int k = pfm_pkg::MAX_DEGREE_DEF - 1; k > 0; k--) stages[k] = stages[k-1];
    stages[0] = d[2:0];
    if (p == 2)      sym = (d != 0) ? 1 : -1;
    else if (p == 3) sym = (d == 2) ? -1 : int'(d);
    else             sym = (d == 4) ? -1 : (d == 3) ? -2 : int'(d);
    e.symbol    = sym[2:0];
    e.raw_digit = d[2:0];
    if (int'(symbol_pos) + 1 >= int'(period_len)) begin
      e.period_end = 1'b1;
      symbol_pos   = '0;
    end else begin
      e.period_end = 1'b0;
      symbol_pos   = symbol_pos + 1'b1;
    end
    expected_symbols.push_back(e);
  endtask

  task automatic write_reg(input pfm_pkg::reg_idx_e idx,
                           input logic [pfm_pkg::CFG_DATA_W-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
  endtask

  // unused upper data bits carry noise; the block must ignore them
  task automatic set_config(input base_code_t b, input degree_t deg,
                            input weights_t wl, input weights_t wh,
                            input period_t per);
    logic [63:0] noise;
    noise = {$urandom, $urandom};
    write_reg(pfm_pkg::REG_BASE,   {noise[pfm_pkg::CFG_DATA_W-1:pfm_pkg::BASE_W], b});
    write_reg(pfm_pkg::REG_DEGREE, {noise[pfm_pkg::CFG_DATA_W-1:pfm_pkg::DEGREE_W], deg});
    write_reg(pfm_pkg::REG_W_LOW,  wl);
    write_reg(pfm_pkg::REG_W_HIGH, wh);
    write_reg(pfm_pkg::REG_PERIOD, {noise[pfm_pkg::CFG_DATA_W-1:pfm_pkg::POS_W], per});
    cfg_we_i    <= 1'b0;
    base_code   = b;
    stage_count = deg;
    taps_low    = wl;
    taps_high   = wh;
    period_len  = per;
  endtask

  task automatic send_request(input bit restart);
    int gap;
    gap = tx_gaps ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    restart_i  <= restart;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    next_symbol(restart);
  endtask

  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_symbols.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic test_reset_defaults();
    tx_gaps   = 1'b0;
    rx_stalls = 1'b0;
    repeat (5) send_request(1'b0);
    send_request(1'b1);
    repeat (2) send_request(1'b0);
    wait_for_results();
  endtask

  task automatic test_config_extremes();
    tx_gaps   = 1'b1;
    rx_stalls = 1'b1;
    set_config(pfm_pkg::BASE_TER, 5'd30, ALL_SEVENS, ALL_SEVENS, 30'd1);
    send_request(1'b0);
    send_request(1'b1);
    repeat (2) send_request(1'b0);
    wait_for_results();
    // degree above the stage count, period of zero
    set_config(pfm_pkg::BASE_QUI, 5'd31, ALL_SEVENS, ALL_SEVENS, 30'd0);
    repeat (4) send_request(1'b0);
    wait_for_results();
    // unused base code with no active stages
    set_config(BASE_SPARE, 5'd0, ALL_SEVENS, '0, PERIOD_MAX);
    repeat (3) send_request(1'b0);
    wait_for_results();
    set_config(pfm_pkg::BASE_QUI, 5'd2, 45'o12, '0, 30'd3);
    repeat (2) send_request(1'b0);
    send_request(1'b1);
    send_request(1'b0);
    wait_for_results();
  endtask

  task automatic test_random_sequences();
    base_code_t      b;
    degree_t         deg;
    weights_t        wl;
    weights_t        wh;
    period_t         per;
    logic [63:0]     r;
    int unsigned     p;
    longint unsigned full;
    int              n;
    for (int ph = 0; ph < 13; ph++) begin
      b = base_code_t'($urandom_range(0, 3));
      p = (b == pfm_pkg::BASE_TER) ? 3 : (b == pfm_pkg::BASE_QUI) ? 5 : 2;
      case ($urandom_range(0, 9))
        0:       deg = degree_t'($urandom_range(0, 1));
        1:       deg = 5'd31;
        default: deg = degree_t'($urandom_range(2, 30));
      endcase
      r  = {$urandom, $urandom};
      wl = r[pfm_pkg::WEIGHTS_W-1:0];
      r  = {$urandom, $urandom};
      wh = r[pfm_pkg::WEIGHTS_W-1:0];
      if ($urandom_range(0, 1)) begin
        for (int k = 0; k < 15; k++) begin
          wl[3*k +: 3] = pfm_pkg::digit_t'(wl[3*k +: 3] % p);
          wh[3*k +: 3] = pfm_pkg::digit_t'(wh[3*k +: 3] % p);
        end
      end
      full = 1;
      for (int k = 0; k < deg; k++) if (full < 64'h4000_0000) full = full * p;
      case ($urandom_range(0, 7))
        0:       per = period_t'($urandom_range(0, 1));
        1:       per = PERIOD_MAX;
        2:       per = period_t'($urandom);
        3:       per = (full - 1 > PERIOD_MAX) ? PERIOD_MAX : period_t'(full - 1);
        default: per = period_t'($urandom_range(3, 40));
      endcase
      set_config(b, deg, wl, wh, per);
      tx_gaps   = ($urandom_range(0, 3) != 0);
      rx_stalls = ($urandom_range(0, 3) != 0);
      n = $urandom_range(35, 65);
      for (int i = 0; i < n; i++) begin
        send_request($urandom_range(0, 24) == 0);
        if (ph == 4 && i == n / 2) wait_for_results();
      end
      wait_for_results();
    end
  endtask

  always @(posedge clk_i) begin
    m_symbol_t e;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_symbols.size() == 0) begin
          $error("result with no request pending: symbol %0d", symbol_o);
          mismatch_count++;
        end else begin
          e = expected_symbols.pop_front();
          if (symbol_o !== e.symbol) begin
            $error("symbol: expected %0d, got %0d", e.symbol, symbol_o);
            mismatch_count++;
          end
          if (raw_digit_o !== e.raw_digit) begin
            $error("raw_digit: expected %0d, got %0d", e.raw_digit, raw_digit_o);
            mismatch_count++;
          end
          if (period_end_o !== e.period_end) begin
            $error("period_end: expected %0d, got %0d", e.period_end, period_end_o);
            mismatch_count++;
          end
        end
        stall_left = rx_stalls ? $urandom_range(0, 9) : 0;
      end
      if (stall_left > 0) begin
        out_stall_i <= 1'b1;
        stall_left--;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin
    reset_model();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_config_extremes();
    test_random_sequences();
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #(2_000_000);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

/* prime_field_m_sequence_generator.f */
src/pfm_pkg.sv
src/pfm_cfg_regs.sv
src/pfm_feedback.sv
src/prime_field_m_sequence_generator.sv
src/pfm_checker.sv
sim/prime_field_m_sequence_generator_test.sv
